>>> sv/sle_pkg.sv
// Shared types, constants and the default keymap for the scan code line editor.
// No dependencies; sle_keymap, scancode_line_editor and the bench import this package.
package sle_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int CNT_W      = 6;
  localparam int CHAR_W     = 8;
  localparam int KMAP_AW    = 9;

  localparam logic [CHAR_W-1:0] SC_LSHIFT = 8'h2A;
  localparam logic [CHAR_W-1:0] SC_RSHIFT = 8'h36;
  localparam logic [CHAR_W-1:0] SC_CAPS   = 8'h3A;
  localparam int                SC_BREAK_BIT = 7;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_CASE  = 8'h20;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2
  } item_kind_t;

  typedef enum logic {
    CFG_ECHO_ENABLE = 1'b0,
    CFG_LINE_LIMIT  = 1'b1
  } cfg_index_t;

  // Default keymap: lower bank plain, upper bank shifted.
  function automatic logic [CHAR_W-1:0] keymap_lookup(input logic [KMAP_AW-1:0] addr);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    case (addr)
      9'h001: ch = 8'h1B; 9'h002: ch = 8'h31; 9'h003: ch = 8'h32; 9'h004: ch = 8'h33;
      9'h005: ch = 8'h34; 9'h006: ch = 8'h35; 9'h007: ch = 8'h36; 9'h008: ch = 8'h37;
      9'h009: ch = 8'h38; 9'h00A: ch = 8'h39; 9'h00B: ch = 8'h30; 9'h00C: ch = 8'h27;
      9'h00D: ch = 8'hEC; 9'h00E: ch = 8'h08; 9'h00F: ch = 8'h09; 9'h010: ch = 8'h71;
      9'h011: ch = 8'h77; 9'h012: ch = 8'h65; 9'h013: ch = 8'h72; 9'h014: ch = 8'h74;
      9'h015: ch = 8'h79; 9'h016: ch = 8'h75; 9'h017: ch = 8'h69; 9'h018: ch = 8'h6F;
      9'h019: ch = 8'h70; 9'h01A: ch = 8'hE8; 9'h01B: ch = 8'h2B; 9'h01C: ch = 8'h0A;
      9'h01E: ch = 8'h61; 9'h01F: ch = 8'h73; 9'h020: ch = 8'h64; 9'h021: ch = 8'h66;
      9'h022: ch = 8'h67; 9'h023: ch = 8'h68; 9'h024: ch = 8'h6A; 9'h025: ch = 8'h6B;
      9'h026: ch = 8'h6C; 9'h027: ch = 8'hF2; 9'h028: ch = 8'hE0; 9'h029: ch = 8'h5C;
      9'h02B: ch = 8'hF9; 9'h02C: ch = 8'h7A; 9'h02D: ch = 8'h78; 9'h02E: ch = 8'h63;
      9'h02F: ch = 8'h76; 9'h030: ch = 8'h62; 9'h031: ch = 8'h6E; 9'h032: ch = 8'h6D;
      9'h033: ch = 8'h2C; 9'h034: ch = 8'h2E; 9'h035: ch = 8'h2D; 9'h037: ch = 8'h2A;
      9'h039: ch = 8'h20; 9'h04A: ch = 8'h2D; 9'h04E: ch = 8'h2B;
      9'h101: ch = 8'h1B; 9'h102: ch = 8'h21; 9'h103: ch = 8'h22; 9'h104: ch = 8'hA3;
      9'h105: ch = 8'h24; 9'h106: ch = 8'h25; 9'h107: ch = 8'h26; 9'h108: ch = 8'h2F;
      9'h109: ch = 8'h28; 9'h10A: ch = 8'h29; 9'h10B: ch = 8'h3D; 9'h10C: ch = 8'h3F;
      9'h10D: ch = 8'h5E; 9'h10E: ch = 8'h08; 9'h10F: ch = 8'h09; 9'h110: ch = 8'h51;
      9'h111: ch = 8'h57; 9'h112: ch = 8'h45; 9'h113: ch = 8'h52; 9'h114: ch = 8'h54;
      9'h115: ch = 8'h59; 9'h116: ch = 8'h55; 9'h117: ch = 8'h49; 9'h118: ch = 8'h4F;
      9'h119: ch = 8'h50; 9'h11A: ch = 8'hE9; 9'h11B: ch = 8'h2A; 9'h11C: ch = 8'h0A;
      9'h11E: ch = 8'h41; 9'h11F: ch = 8'h53; 9'h120: ch = 8'h44; 9'h121: ch = 8'h46;
      9'h122: ch = 8'h47; 9'h123: ch = 8'h48; 9'h124: ch = 8'h4A; 9'h125: ch = 8'h4B;
      9'h126: ch = 8'h4C; 9'h127: ch = 8'hE7; 9'h128: ch = 8'hB0; 9'h129: ch = 8'h7C;
      9'h12B: ch = 8'hA7; 9'h12C: ch = 8'h5A; 9'h12D: ch = 8'h58; 9'h12E: ch = 8'h43;
      9'h12F: ch = 8'h56; 9'h130: ch = 8'h42; 9'h131: ch = 8'h4E; 9'h132: ch = 8'h4D;
      9'h133: ch = 8'h3B; 9'h134: ch = 8'h3A; 9'h135: ch = 8'h5F; 9'h137: ch = 8'h2A;
      9'h139: ch = 8'h20; 9'h14A: ch = 8'h2D; 9'h14E: ch = 8'h2B;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

>>> sv/sle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sle_keymap.sv
// Keymap ROM with registered read; bank select in the top address bit.
// Depends on sle_pkg for the keymap contents.
module sle_keymap
  import sle_pkg::*;
(
  input  logic                    clk,
  input  logic [KMAP_AW-1:0]      addr,
  output logic [CHAR_W-1:0]       data
);

  always_ff @(posedge clk) begin
    data <= keymap_lookup(addr);
  end

endmodule

>>> sv/scancode_line_editor.sv
// Scan code line editor top level: decode, line RAM sequencing and output register.
// Depends on sle_pkg, sle_keymap and sle_ram.
//
// Takes set-1 scan codes one request at a time and gives echo, line and line-end
// requests. A modifier or release code is handled as it is accepted; any other code
// is accepted, then mapped by a keymap ROM read, then echoed if an echo is due. A
// newline is accepted and mapped, echoed, then each stored character comes out of the
// line RAM read port, then the line-end request. Stalls on out_tready hold the echo and
// the walk. in_tready is low while a code is being worked on. No clearing pass after reset.
module scancode_line_editor
  import sle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scan_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] item_kind, [9:2] char_value, [15:10] line_length
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [5:0]  cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_EMIT,
    ST_WALK
  } state_t;

  state_t             state_r;
  logic               shift_r;
  logic               caps_r;
  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   idx_r;
  logic               echo_r;
  logic [CNT_W-1:0]   limit_r;
  logic [CHAR_W-1:0]  pend_char_r;
  logic               pend_last_r;
  logic               nl_r;

  logic               out_valid_r;
  item_kind_t         out_kind_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic [CNT_W-1:0]   out_len_r;
  logic               out_last_r;

  logic [CHAR_W-1:0]  rom_q;
  logic [CHAR_W-1:0]  mapped_ch;
  logic [CHAR_W-1:0]  ram_q;
  logic [CNT_W-1:0]   eff_limit;
  logic [CNT_W-1:0]   rd_idx;
  logic               can_emit;
  logic               append_ok;
  logic               ram_we;
  logic               shift_code;

  sle_keymap u_keymap (
    .clk  (clk),
    .addr ({shift_r, in_tdata}),
    .data (rom_q)
  );

  sle_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[LINE_AW-1:0]),
    .wdata (mapped_ch),
    .raddr (rd_idx[LINE_AW-1:0]),
    .rdata (ram_q)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_char_r, out_kind_r};
  assign out_tlast  = out_last_r;
  assign can_emit   = !out_valid_r || out_tready;

  assign shift_code = ({1'b0, in_tdata[6:0]} == SC_LSHIFT) ||
                      ({1'b0, in_tdata[6:0]} == SC_RSHIFT);

  always_comb begin
    mapped_ch = rom_q;
    if (caps_r && (rom_q inside {[CH_LOW_A:CH_LOW_Z]})) begin
      mapped_ch = rom_q - CH_CASE;
    end
    eff_limit = (limit_r > CNT_W'(LINE_DEPTH)) ? CNT_W'(LINE_DEPTH) : limit_r;
    append_ok = (mapped_ch != '0) && (mapped_ch != CH_NL) && (mapped_ch != CH_BS) &&
                (fill_r < eff_limit);
    ram_we    = (state_r == ST_MAP) && append_ok;
    // Look one entry ahead so the read data lines up with idx_r in the walk.
    if (state_r == ST_WALK) begin
      rd_idx = (can_emit && (idx_r != fill_r)) ? idx_r + 1'b1 : idx_r;
    end else begin
      rd_idx = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      shift_r     <= 1'b0;
      caps_r      <= 1'b0;
      fill_r      <= '0;
      idx_r       <= '0;
      echo_r      <= 1'b1;
      limit_r     <= CNT_W'(32);
      out_valid_r <= 1'b0;
      nl_r        <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ECHO_ENABLE: echo_r  <= cfg_wdata[0];
          CFG_LINE_LIMIT:  limit_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            if (in_tdata[SC_BREAK_BIT]) begin
              if (shift_code) begin
                shift_r <= 1'b0;
              end
            end else if (shift_code) begin
              shift_r <= 1'b1;
            end else if (in_tdata == SC_CAPS) begin
              caps_r <= ~caps_r;
            end else begin
              state_r <= ST_MAP;
            end
          end
        end

        ST_MAP: begin
          nl_r        <= 1'b0;
          pend_last_r <= 1'b1;
          pend_char_r <= mapped_ch;
          state_r     <= ST_IDLE;
          if (mapped_ch == CH_NL) begin
            // newline echoes regardless of echo_enable; the line end closes the run
            nl_r        <= 1'b1;
            pend_last_r <= 1'b0;
            state_r     <= ST_EMIT;
          end else if (mapped_ch == CH_BS) begin
            if (fill_r != '0) begin
              fill_r <= fill_r - 1'b1;
              if (echo_r) begin
                state_r <= ST_EMIT;
              end
            end
          end else if (append_ok) begin
            fill_r <= fill_r + 1'b1;
            if (echo_r) begin
              state_r <= ST_EMIT;
            end
          end
        end

        ST_EMIT: begin
          if (can_emit) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_ECHO;
            out_char_r  <= pend_char_r;
            out_len_r   <= '0;
            out_last_r  <= pend_last_r;
            idx_r       <= '0;
            state_r     <= nl_r ? ST_WALK : ST_IDLE;
          end
        end

        ST_WALK: begin
          if (can_emit) begin
            out_valid_r <= 1'b1;
            if (idx_r == fill_r) begin
              out_kind_r <= KIND_END;
              out_char_r <= '0;
              out_len_r  <= fill_r;
              out_last_r <= 1'b1;
              fill_r     <= '0;
              state_r    <= ST_IDLE;
            end else begin
              out_kind_r <= KIND_LINE;
              out_char_r <= ram_q;
              out_len_r  <= '0;
              out_last_r <= 1'b0;
              idx_r      <= idx_r + 1'b1;
            end
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> test/scancode_line_editor_test.sv
`timescale 1ns / 1ps
// Self-checking bench for scancode_line_editor: scan code stream in, echo/line/end stream out.
// Depends on sle_pkg and the scancode_line_editor RTL; predicts results with its own keymap.
module scancode_line_editor_test;
  import sle_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int KEY_ROWS     = 79;

  typedef struct packed {
    item_kind_t       kind;
    logic [7:0]       ch;
    logic [CNT_W-1:0] len;
    logic             last;
  } editor_item_t;

  class line_echo_board;
    logic [7:0]       plain_keys [KEY_ROWS];
    logic [7:0]       shift_keys [KEY_ROWS];
    logic [7:0]       line_chars [LINE_DEPTH];
    logic             echo_on;
    logic [CNT_W-1:0] limit_reg;
    logic             shift_down;
    logic             caps_down;
    logic [CNT_W-1:0] fill;
    editor_item_t     awaited [$];
    int               mismatches;

    function new();
      plain_keys = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
        8'h27, 8'hEC, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'hE8, 8'h2B, 8'h0A, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
        8'h6A, 8'h6B, 8'h6C, 8'hF2, 8'hE0, 8'h5C, 8'h00, 8'hF9, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B};
      shift_keys = '{
        8'h00, 8'h1B, 8'h21, 8'h22, 8'hA3, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h28, 8'h29, 8'h3D,
        8'h3F, 8'h5E, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'hE9, 8'h2A, 8'h0A, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
        8'h4A, 8'h4B, 8'h4C, 8'hE7, 8'hB0, 8'h7C, 8'h00, 8'hA7, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B};
      echo_on    = 1'b1;
      limit_reg  = CNT_W'(LINE_DEPTH);
      shift_down = 1'b0;
      caps_down  = 1'b0;
      fill       = '0;
      mismatches = 0;
    endfunction

    function void write_register(cfg_index_t idx, logic [CNT_W-1:0] value);
      if (idx == CFG_ECHO_ENABLE) begin
        echo_on = value[0];
      end else begin
        limit_reg = value;
      end
    endfunction

    // Update modifier state and return the character a code types, zero for none.
    function logic [7:0] translate(logic [7:0] code);
      logic [7:0] ch;
      logic [7:0] low;
      ch  = '0;
      low = {1'b0, code[6:0]};
      if (code[SC_BREAK_BIT]) begin
        if (low == SC_LSHIFT || low == SC_RSHIFT) shift_down = 1'b0;
      end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
        shift_down = 1'b1;
      end else if (code == SC_CAPS) begin
        caps_down = !caps_down;
      end else begin
        if (code < KEY_ROWS) ch = shift_down ? shift_keys[code] : plain_keys[code];
        if (caps_down && ch >= CH_LOW_A && ch <= CH_LOW_Z) ch = ch - CH_CASE;
      end
      return ch;
    endfunction

    function editor_item_t make_item(item_kind_t kind, logic [7:0] ch, logic [CNT_W-1:0] len);
      editor_item_t it;
      it.kind = kind;
      it.ch   = ch;
      it.len  = len;
      it.last = 1'b0;
      return it;
    endfunction

    // Queue the results of one accepted code.
    function void note_scan_code(logic [7:0] code);
      editor_item_t     run [$];
      logic [7:0]       ch;
      logic [CNT_W-1:0] cap;
      ch    = translate(code);
      cap   = (limit_reg > LINE_DEPTH) ? CNT_W'(LINE_DEPTH) : limit_reg;
      if (ch == CH_NL) begin
        run.push_back(make_item(KIND_ECHO, CH_NL, '0));
        for (int i = 0; i < fill; i++) run.push_back(make_item(KIND_LINE, line_chars[i], '0));
        run.push_back(make_item(KIND_END, '0, fill));
        fill = '0;
      end else if (ch == CH_BS) begin
        if (fill != 0) begin
          fill = fill - 1'b1;
          if (echo_on) run.push_back(make_item(KIND_ECHO, CH_BS, '0));
        end
      end else if (ch != 0 && fill < cap) begin
        line_chars[fill[LINE_AW-1:0]] = ch;
        fill = fill + 1'b1;
        if (echo_on) run.push_back(make_item(KIND_ECHO, ch, '0));
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) awaited.push_back(run[i]);
    endfunction

    function void check_output(logic [15:0] data, logic last);
      editor_item_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected request: kind %0d char %02h len %0d last %0b",
                   data[1:0], data[9:2], data[15:10], last);
        return;
      end
      want = awaited.pop_front();
      if (data[1:0] !== want.kind || data[9:2] !== want.ch ||
          data[15:10] !== want.len || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected kind %0d char %02h len %0d last %0b, got %0d %02h %0d %0b",
                   want.kind, want.ch, want.len, want.last,
                   data[1:0], data[9:2], data[15:10], last);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;   // [7:0] scan_code
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      out_tdata;       // [1:0] item_kind, [9:2] char_value, [15:10] line_length
  logic             out_tlast;       // last_of_run
  logic             cfg_we = 1'b0;
  logic             cfg_addr = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  bit              steady = 1'b0;
  int              quiet_cycles = 0;
  line_echo_board  board = new();

  // Shift, caps, zero-map, release, backspace and newline corners.
  logic [7:0] opening [23] = '{
    8'h1E, 8'h2A, 8'h1E, 8'hAA, 8'h3A, 8'h10, 8'h02, 8'hBA, 8'h36, 8'h1E, 8'h0E, 8'hB6,
    8'h3A, 8'h0D, 8'h1D, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h1C, 8'h0E, 8'h1C, 8'h4E};

  scancode_line_editor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_output(out_tdata, out_tlast);
    out_tready <= rst_n && (steady || $urandom_range(0, 99) >= 27);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_code(int nl_pct);
    int         r;
    logic [7:0] code;
    r = $urandom_range(0, 99);
    if (r < nl_pct) begin
      code = 8'h1C;
    end else if (r < nl_pct + 8) begin
      code = 8'h0E;
    end else if (r < nl_pct + 16) begin
      case ($urandom_range(0, 3))
        0:       code = SC_LSHIFT;
        1:       code = SC_RSHIFT;
        2:       code = SC_LSHIFT | 8'h80;
        default: code = SC_RSHIFT | 8'h80;
      endcase
    end else if (r < nl_pct + 18) begin
      code = SC_CAPS;
    end else if (r < nl_pct + 30) begin
      code = 8'($urandom_range(0, 255));
    end else begin
      // codes 01h to 39h, with shift, newline and backspace left out
      do code = 8'($urandom_range(1, 8'h39));
      while (code == SC_LSHIFT || code == SC_RSHIFT || code == 8'h1C || code == 8'h0E);
    end
    return code;
  endfunction

  task automatic send_code(input logic [7:0] code);
    if (!steady && $urandom_range(0, 99) < 27) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_scan_code(code);
  endtask

  // Drop valid and hold until every expected request has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  // Drain, then give a code that left no result time to finish.
  task automatic settle();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    board.write_register(idx, value);
  endtask

  task automatic run_phase(input logic echo, input logic [CNT_W-1:0] limit,
                           input int nl_pct, input int count, input bit quiet);
    int applied;
    applied = 0;
    settle();
    write_reg(CFG_ECHO_ENABLE, {5'd0, echo});
    write_reg(CFG_LINE_LIMIT, limit);
    cfg_we <= 1'b0;
    steady = quiet;
    while (applied < count) begin
      if (applied == count / 2) drain();
      send_code(pick_code(nl_pct));
      applied++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening[i]) send_code(opening[i]);
    run_phase(1'b1, 6'd32, 2, 90, 1'b0);
    run_phase(1'b0, 6'd5, 8, 60, 1'b1);
    run_phase(1'b1, 6'd0, 10, 40, 1'b0);
    run_phase(1'b1, 6'd63, 2, 90, 1'b0);
    run_phase(1'b0, 6'd1, 10, 40, 1'b0);
    run_phase(1'b1, 6'd17, 5, 80, 1'b0);
    settle();
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sle_pkg.sv
sv/sle_ram.sv
sv/sle_keymap.sv
sv/scancode_line_editor.sv
test/scancode_line_editor_test.sv
